@@ hw/rtl/lya_pkg.sv @@
// lya_pkg: shared types, constants and the arctangent table for the line yaw core
// no dependencies
`timescale 1ns / 1ps

package lya_pkg;

    localparam int COORD_W    = 17;
    localparam int DIFF_W     = 18;
    localparam int CFG_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int PROD_W     = 50;
    localparam int D34_W      = 52;
    localparam int D28_W      = 46;
    localparam int SPLIT_LO   = 23;
    localparam int DEN_W      = 64;
    localparam int CRD_W      = 43;
    localparam int ANG_W      = 33;
    localparam int YAW_W      = 16;
    localparam int ATAN_SIZE  = 24;
    localparam int ANGLE_ITERATIONS_DEF = 16;
    localparam int QUEUE_DEPTH_DEF      = 4;
    localparam logic [YAW_W-1:0] HALF_PI_Q14 = 16'd25736;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INV_FX      = 3'd0,
        REG_INV_SKEW    = 3'd1,
        REG_INV_CX_TERM = 3'd2,
        REG_INV_FY      = 3'd3,
        REG_INV_CY_TERM = 3'd4
    } t_reg_idx;

    // one segment waiting for the back end
    typedef struct packed {
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic signed [D28_W-1:0]  dx28;
        logic signed [D28_W-1:0]  dy28;
        logic                     last;
    } t_seg;

    // per-item flags carried through the back end
    typedef struct packed {
        logic degen;
        logic vert;
        logic flat;
        logic neg;
        logic last;
    } t_flags;

    // arctangent of 2^-i, 30 fraction bits
    function automatic logic signed [31:0] atan_q30(input int idx);
        logic signed [31:0] v;
        case (idx)
            0:  v = 32'sd843314857;
            1:  v = 32'sd497837830;
            2:  v = 32'sd263043837;
            3:  v = 32'sd133525159;
            4:  v = 32'sd67021687;
            5:  v = 32'sd33543516;
            6:  v = 32'sd16775851;
            7:  v = 32'sd8388437;
            8:  v = 32'sd4194283;
            9:  v = 32'sd2097149;
            10: v = 32'sd1048576;
            11: v = 32'sd524288;
            12: v = 32'sd262144;
            13: v = 32'sd131072;
            14: v = 32'sd65536;
            15: v = 32'sd32768;
            16: v = 32'sd16384;
            17: v = 32'sd8192;
            18: v = 32'sd4096;
            19: v = 32'sd2048;
            20: v = 32'sd1024;
            21: v = 32'sd512;
            22: v = 32'sd256;
            23: v = 32'sd128;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

endpackage

@@ hw/rtl/line_yaw_angle_core.sv @@
// line_yaw_angle_core: top level of the line yaw angle block
// depends on lya_pkg, lya_front, lya_fifo, lya_back
`timescale 1ns / 1ps

// usage
// - input channel: i_valid / o_stall with the two endpoints and i_in_last;
//   a transaction completes on a rising edge with i_valid high and o_stall low
// - output channel: o_valid / i_stall with o_yaw, o_degenerate, o_out_last;
//   one result per segment, in arrival order
// - configuration: i_cfg_we, i_cfg_idx, i_cfg_data load the five inverse matrix
//   entries (q2.30); write only while the block is empty, unknown indexes ignored
// - throughput: one segment per cycle while nothing stalls, set by the fully
//   pipelined multiply and cordic path (one cordic iteration per stage)
// - path from input transaction to o_valid: 2 front stages, queue write,
//   3 denominator stages, 6 normalisation stages, entry stage, cordic stages,
//   output register
// - an output stall with o_valid high freezes the back end; the queue between front and
//   back keeps taking segments until it fills, then o_stall rises
// - reset (synchronous, active low) empties all stages and the queue and
//   clears the matrix registers to zero

module line_yaw_angle_core #(
    parameter int ANGLE_ITERATIONS = lya_pkg::ANGLE_ITERATIONS_DEF,
    parameter int QUEUE_DEPTH      = lya_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [lya_pkg::COORD_W-1:0]         i_start_x,
    input  logic [lya_pkg::COORD_W-1:0]         i_start_y,
    input  logic [lya_pkg::COORD_W-1:0]         i_end_x,
    input  logic [lya_pkg::COORD_W-1:0]         i_end_y,
    input  logic                                i_in_last,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [lya_pkg::YAW_W-1:0]    o_yaw,
    output logic                                o_degenerate,
    output logic                                o_out_last,
    input  logic                                i_cfg_we,
    input  logic [lya_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [lya_pkg::CFG_W-1:0]           i_cfg_data
);

    // inverse camera matrix entries
    logic signed [lya_pkg::CFG_W-1:0] r_inv_fx;
    logic signed [lya_pkg::CFG_W-1:0] r_inv_skew;
    logic signed [lya_pkg::CFG_W-1:0] r_inv_cx_term;
    logic signed [lya_pkg::CFG_W-1:0] r_inv_fy;
    logic signed [lya_pkg::CFG_W-1:0] r_inv_cy_term;

    logic          q_full;
    logic          q_empty;
    logic          push;
    logic          pop;
    lya_pkg::t_seg seg_in;
    lya_pkg::t_seg seg_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_fx      <= '0;
            r_inv_skew    <= '0;
            r_inv_cx_term <= '0;
            r_inv_fy      <= '0;
            r_inv_cy_term <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lya_pkg::REG_INV_FX:      r_inv_fx      <= i_cfg_data;
                lya_pkg::REG_INV_SKEW:    r_inv_skew    <= i_cfg_data;
                lya_pkg::REG_INV_CX_TERM: r_inv_cx_term <= i_cfg_data;
                lya_pkg::REG_INV_FY:      r_inv_fy      <= i_cfg_data;
                lya_pkg::REG_INV_CY_TERM: r_inv_cy_term <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // front: accept, back-project first endpoint, endpoint differences
    lya_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_start_x     (i_start_x),
        .i_start_y     (i_start_y),
        .i_end_x       (i_end_x),
        .i_end_y       (i_end_y),
        .i_in_last     (i_in_last),
        .i_inv_fx      (r_inv_fx),
        .i_inv_skew    (r_inv_skew),
        .i_inv_cx_term (r_inv_cx_term),
        .i_inv_fy      (r_inv_fy),
        .i_inv_cy_term (r_inv_cy_term),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_seg         (seg_in)
    );

    // queue decoupling front stalls from back stalls
    lya_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_seg   (seg_in),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_seg   (seg_out)
    );

    // back: denominator, normalisation, cordic, output register
    lya_back #(
        .ANGLE_ITERATIONS (ANGLE_ITERATIONS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (q_empty),
        .o_pop        (pop),
        .i_seg        (seg_out),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_yaw        (o_yaw),
        .o_degenerate (o_degenerate),
        .o_out_last   (o_out_last)
    );

    // a degenerate line always reports zero
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_degenerate) |-> (o_yaw == '0))
        else $error("degenerate line with non-zero yaw");

    // yaw stays inside (-pi/2, pi/2]
    a_yaw_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_yaw <= $signed(lya_pkg::HALF_PI_Q14))
                  && (o_yaw > -$signed(lya_pkg::HALF_PI_Q14))))
        else $error("yaw out of range");

    // nothing emerges straight after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

@@ hw/rtl/lya_front.sv @@
// lya_front: accepts segments, back-projects the first endpoint, forms dx and dy
// depends on lya_pkg
`timescale 1ns / 1ps

module lya_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [lya_pkg::COORD_W-1:0]          i_start_x,
    input  logic [lya_pkg::COORD_W-1:0]          i_start_y,
    input  logic [lya_pkg::COORD_W-1:0]          i_end_x,
    input  logic [lya_pkg::COORD_W-1:0]          i_end_y,
    input  logic                                 i_in_last,
    input  logic signed [lya_pkg::CFG_W-1:0]     i_inv_fx,
    input  logic signed [lya_pkg::CFG_W-1:0]     i_inv_skew,
    input  logic signed [lya_pkg::CFG_W-1:0]     i_inv_cx_term,
    input  logic signed [lya_pkg::CFG_W-1:0]     i_inv_fy,
    input  logic signed [lya_pkg::CFG_W-1:0]     i_inv_cy_term,
    input  logic                                 i_q_full,
    output logic                                 o_push,
    output lya_pkg::t_seg                        o_seg
);

    logic                                  en;
    logic                                  r_v1;
    logic                                  r_v2;
    logic signed [lya_pkg::PROD_W-1:0]     r_p_fx;
    logic signed [lya_pkg::PROD_W-1:0]     r_p_sk;
    logic signed [lya_pkg::PROD_W-1:0]     r_p_fy;
    logic signed [lya_pkg::DIFF_W-1:0]     r_dx1;
    logic signed [lya_pkg::DIFF_W-1:0]     r_dy1;
    logic                                  r_last1;
    lya_pkg::t_seg                         r_seg;
    logic signed [lya_pkg::D34_W-1:0]      dx34;
    logic signed [lya_pkg::D34_W-1:0]      dy34;

    assign en      = !(r_v2 && i_q_full);
    assign o_stall = !en;
    assign o_push  = r_v2 && !i_q_full;
    assign o_seg   = r_seg;

    // sum of products, 34 fraction bits
    assign dx34 = lya_pkg::D34_W'(r_p_fx) + lya_pkg::D34_W'(r_p_sk)
                + (lya_pkg::D34_W'(i_inv_cx_term) <<< 4);
    assign dy34 = lya_pkg::D34_W'(r_p_fy) + (lya_pkg::D34_W'(i_inv_cy_term) <<< 4);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p_fx  <= i_inv_fx   * $signed({1'b0, i_start_x});
            r_p_sk  <= i_inv_skew * $signed({1'b0, i_start_y});
            r_p_fy  <= i_inv_fy   * $signed({1'b0, i_start_y});
            r_dx1   <= $signed({1'b0, i_end_x}) - $signed({1'b0, i_start_x});
            r_dy1   <= $signed({1'b0, i_end_y}) - $signed({1'b0, i_start_y});
            r_last1 <= i_in_last;
            r_seg.dx   <= r_dx1;
            r_seg.dy   <= r_dy1;
            r_seg.dx28 <= lya_pkg::D28_W'(dx34 >>> 6);
            r_seg.dy28 <= lya_pkg::D28_W'(dy34 >>> 6);
            r_seg.last <= r_last1;
        end
    end

endmodule

@@ hw/rtl/lya_fifo.sv @@
// lya_fifo: short queue of segments between front and back
// depends on lya_pkg
`timescale 1ns / 1ps

module lya_fifo #(
    parameter int DEPTH = lya_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  lya_pkg::t_seg i_seg,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output lya_pkg::t_seg o_seg
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    lya_pkg::t_seg   r_mem [DEPTH];
    logic [PW-1:0]   r_wp;
    logic [PW-1:0]   r_rp;
    logic [CW-1:0]   r_cnt;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_seg   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + CW'(do_push) - CW'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_seg;
        end
    end

endmodule

@@ hw/rtl/lya_back.sv @@
// lya_back: denominator, sign fold, normalisation, cordic vectoring and output register
// depends on lya_pkg
`timescale 1ns / 1ps

module lya_back #(
    parameter int ANGLE_ITERATIONS = lya_pkg::ANGLE_ITERATIONS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_empty,
    output logic                              o_pop,
    input  lya_pkg::t_seg                     i_seg,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [lya_pkg::YAW_W-1:0]  o_yaw,
    output logic                              o_degenerate,
    output logic                              o_out_last
);

    localparam int N  = ANGLE_ITERATIONS;
    localparam int LO = lya_pkg::SPLIT_LO;
    localparam int HW = lya_pkg::D28_W - LO;
    localparam int DW = lya_pkg::DEN_W;
    localparam int CW = lya_pkg::CRD_W;
    localparam int AW = lya_pkg::ANG_W;
    localparam int YW = lya_pkg::YAW_W;

    logic en;

    // b1: partial products
    logic                                       r_v1;
    logic signed [lya_pkg::DIFF_W+LO:0]         r_pa_lo, r_pb_lo;
    logic signed [lya_pkg::DIFF_W+HW-1:0]       r_pa_hi, r_pb_hi;
    logic signed [lya_pkg::DIFF_W-1:0]          r_dy1;
    logic                                       r_last1;
    // b2: denominator
    logic                                       r_v2;
    logic signed [DW-1:0]                       r_den;
    logic signed [lya_pkg::DIFF_W-1:0]          r_dy2;
    logic                                       r_last2;
    logic signed [DW-1:0]                       den_n;
    // b3: sign fold
    logic                                       r_v3;
    logic [DW-1:0]                              r_nx [7];
    logic [DW-1:0]                              r_ny [7];
    logic [DW-1:0]                              r_nm [7];
    logic                                       r_nv [6];
    lya_pkg::t_flags                            r_nf [7];
    logic signed [DW-1:0]                       num_s, den_f, num_f;
    logic [DW-1:0]                              ux, uy;
    lya_pkg::t_flags                            fl;
    // cordic pipeline
    logic signed [CW-1:0]                       r_cx [N+1];
    logic signed [CW-1:0]                       r_cy [N+1];
    logic signed [AW-1:0]                       r_cz [N+1];
    logic                                       r_cv [N+1];
    lya_pkg::t_flags                            r_cf [N+1];
    // output
    logic                                       r_ov;
    logic signed [YW-1:0]                       r_yaw;
    logic                                       r_deg;
    logic                                       r_last;
    logic signed [AW-1:0]                       zc;
    logic [AW-1:0]                              zr;
    logic [YW-1:0]                              mag;
    logic signed [YW-1:0]                       yaw_n;
    lya_pkg::t_flags                            ff;

    assign en    = !(r_ov && i_stall);
    assign o_pop = en && !i_empty;

    assign o_valid      = r_ov;
    assign o_yaw        = r_yaw;
    assign o_degenerate = r_deg;
    assign o_out_last   = r_last;

    // valid chain, r_nv[k] goes with r_nx[k+1]
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            for (int k = 0; k < 6; k++) r_nv[k] <= 1'b0;
            for (int k = 0; k <= N; k++) r_cv[k] <= 1'b0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_v1    <= !i_empty;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            r_nv[0] <= r_v3;
            for (int k = 1; k < 6; k++) r_nv[k] <= r_nv[k-1];
            r_cv[0] <= r_nv[5];
            for (int k = 1; k <= N; k++) r_cv[k] <= r_cv[k-1];
            r_ov    <= r_cv[N];
        end
    end

    // b1: dx*dy28 and dy*dx28, each split into low and high partial products
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pa_lo <= i_seg.dx * $signed({1'b0, i_seg.dy28[LO-1:0]});
            r_pa_hi <= i_seg.dx * $signed(i_seg.dy28[lya_pkg::D28_W-1:LO]);
            r_pb_lo <= i_seg.dy * $signed({1'b0, i_seg.dx28[LO-1:0]});
            r_pb_hi <= i_seg.dy * $signed(i_seg.dx28[lya_pkg::D28_W-1:LO]);
            r_dy1   <= i_seg.dy;
            r_last1 <= i_seg.last;
        end
    end

    // b2: recombine and subtract
    assign den_n = ((DW'(r_pa_hi) <<< LO) + DW'(r_pa_lo))
                 - ((DW'(r_pb_hi) <<< LO) + DW'(r_pb_lo));

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_den   <= den_n;
            r_dy2   <= r_dy1;
            r_last2 <= r_last1;
        end
    end

    // b3: special cases, sign fold and magnitudes
    always_comb begin
        num_s    = DW'(r_dy2) <<< 28;
        den_f    = r_den[DW-1] ? -r_den : r_den;
        num_f    = r_den[DW-1] ? -num_s : num_s;
        fl.degen = (r_dy2 == '0) && (r_den == '0);
        fl.vert  = (r_dy2 != '0) && (r_den == '0);
        fl.flat  = (r_dy2 == '0);
        fl.neg   = num_f[DW-1];
        fl.last  = r_last2;
        ux       = den_f;
        uy       = num_f[DW-1] ? -num_f : num_f;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_nx[0] <= ux;
            r_ny[0] <= uy;
            r_nm[0] <= (ux > uy) ? ux : uy;
            r_nf[0] <= fl;
        end
    end

    // normalise so the larger magnitude has its top bit at bit 63
    for (genvar s = 0; s < 6; s++) begin : g_norm
        localparam int SH = 32 >> s;
        always_ff @(posedge i_clk) begin
            if (en) begin
                if (r_nm[s][DW-1 -: SH] == '0) begin
                    r_nx[s+1] <= r_nx[s] << SH;
                    r_ny[s+1] <= r_ny[s] << SH;
                    r_nm[s+1] <= r_nm[s] << SH;
                end else begin
                    r_nx[s+1] <= r_nx[s];
                    r_ny[s+1] <= r_ny[s];
                    r_nm[s+1] <= r_nm[s];
                end
                r_nf[s+1] <= r_nf[s];
            end
        end
    end

    // cordic entry: top bit lands at bit 39
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cx[0] <= $signed({3'b000, r_nx[6][DW-1 -: 40]});
            r_cy[0] <= $signed({3'b000, r_ny[6][DW-1 -: 40]});
            r_cz[0] <= '0;
            r_cf[0] <= r_nf[6];
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_cordic
        logic signed [CW-1:0] xs, ys;
        assign xs = r_cx[i] >>> i;
        assign ys = r_cy[i] >>> i;
        always_ff @(posedge i_clk) begin
            if (en) begin
                if (r_cy[i] > 0) begin
                    r_cx[i+1] <= r_cx[i] + ys;
                    r_cy[i+1] <= r_cy[i] - xs;
                    r_cz[i+1] <= r_cz[i] + AW'(lya_pkg::atan_q30(i));
                end else begin
                    r_cx[i+1] <= r_cx[i] - ys;
                    r_cy[i+1] <= r_cy[i] + xs;
                    r_cz[i+1] <= r_cz[i] - AW'(lya_pkg::atan_q30(i));
                end
                r_cf[i+1] <= r_cf[i];
            end
        end
    end

    // round to q2.14, clamp, sign and fold
    always_comb begin
        ff    = r_cf[N];
        zc    = r_cz[N][AW-1] ? '0 : r_cz[N];
        zr    = (AW'(zc) + AW'(1 << 15)) >> 16;
        mag   = (zr > AW'(lya_pkg::HALF_PI_Q14)) ? lya_pkg::HALF_PI_Q14 : YW'(zr);
        yaw_n = (ff.neg && mag != lya_pkg::HALF_PI_Q14) ? -$signed(mag) : $signed(mag);
        if (ff.degen || ff.flat) begin
            yaw_n = '0;
        end else if (ff.vert) begin
            yaw_n = $signed(lya_pkg::HALF_PI_Q14);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_yaw  <= yaw_n;
            r_deg  <= ff.degen;
            r_last <= ff.last;
        end
    end

endmodule

@@ dv/line_yaw_angle_core_tb.sv @@
// line_yaw_angle_core_tb: self-checking bench for the line yaw angle core
// drives random and directed segments under several matrix settings and checks each result
// depends on lya_pkg and line_yaw_angle_core
`timescale 1ns / 1ps

module line_yaw_angle_core_tb;
    import lya_pkg::*;

    localparam int  ITERS       = 16;
    localparam int  DRAIN_WAIT  = 45;        // longer than the path through the core
    localparam int  CYCLE_LIMIT = 400000;
    localparam int  RAND_PER_PHASE = 260;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;   // first unused index
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
    localparam longint HALF_PI = 25736;
    localparam logic [COORD_W-1:0] CMAX = '1;

    // arctangent of 2^-i, 30 fraction bits
    localparam longint ARCTAN_Q30 [ITERS] = '{
        843314857, 497837830, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288,
        262144, 131072, 65536, 32768
    };

    typedef struct {
        logic [COORD_W-1:0] sx, sy, ex, ey;
        logic               last;
    } t_line;

    typedef struct {
        logic signed [YAW_W-1:0] yaw;
        logic                    degen;
        logic                    last;
    } t_angle;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_valid = 1'b0;
    logic                    o_stall;
    logic [COORD_W-1:0]      i_start_x = '0, i_start_y = '0, i_end_x = '0, i_end_y = '0;
    logic                    i_in_last = 1'b0;
    logic                    o_valid;
    logic                    i_stall = 1'b0;
    logic signed [YAW_W-1:0] o_yaw;
    logic                    o_degenerate;
    logic                    o_out_last;
    logic                    i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_idx = '0;
    logic [CFG_W-1:0]        i_cfg_data = '0;

    t_line  pending_lines[$];
    t_angle expected_angles[$];
    logic signed [CFG_W-1:0] matrix [5];   // our copy of the inverse matrix entries
    int     error_count = 0;
    int     cycle_count = 0;
    bit     calm = 1'b0;                    // no idling in the closing phase
    int     send_gap = 0;
    int     hold_gap = 0;

    line_yaw_angle_core i_dut (.*);

    always #2 i_clk = ~i_clk;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        error_count++;
        $display("mismatch %s: got %0d, want %0d (cycle %0d)", what, got, want, cycle_count);
    endtask

    // vectoring cordic on (x > 0, y >= 0), returns angle with 30 fraction bits
    function automatic longint vector_angle(input longint ux, input longint uy);
        longint m, x, y, z, xs, ys;
        m = (ux > uy) ? ux : uy;
        z = 0;
        while (m >= (64'sd1 <<< 40)) begin
            ux = ux >>> 1; uy = uy >>> 1; m = m >>> 1;
        end
        while (m < (64'sd1 <<< 39)) begin
            ux = ux <<< 1; uy = uy <<< 1; m = m <<< 1;
        end
        x = ux;
        y = uy;
        for (int i = 0; i < ITERS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x += ys; y -= xs; z += ARCTAN_Q30[i];
            end else begin
                x -= ys; y += xs; z -= ARCTAN_Q30[i];
            end
        end
        return z;
    endfunction

    // expected yaw of one segment under the current matrix
    function automatic t_angle line_yaw(input t_line ln);
        t_angle r;
        longint sx, sy, dx, dy, dx34, dy34, dx28, dy28, num, den, z, mag;
        bit neg;
        sx = longint'(ln.sx);
        sy = longint'(ln.sy);
        dx = longint'(ln.ex) - sx;
        dy = longint'(ln.ey) - sy;
        dx34 = longint'(matrix[REG_INV_FX]) * sx + longint'(matrix[REG_INV_SKEW]) * sy
             + longint'(matrix[REG_INV_CX_TERM]) * 16;
        dy34 = longint'(matrix[REG_INV_FY]) * sy + longint'(matrix[REG_INV_CY_TERM]) * 16;
        dx28 = dx34 >>> 6;      // floor
        dy28 = dy34 >>> 6;
        num = dy <<< 28;
        den = dx * dy28 - dy * dx28;
        r.yaw = '0;
        r.degen = 1'b0;
        r.last = ln.last;
        if (num == 0 && den == 0) begin
            r.degen = 1'b1;
        end else if (den == 0) begin
            r.yaw = YAW_W'(HALF_PI);
        end else if (num != 0) begin
            if (den < 0) begin
                den = -den;
                num = -num;
            end
            neg = num < 0;
            mag = neg ? -num : num;
            z = vector_angle(den, mag);
            if (z < 0) z = 0;
            z = (z + (64'sd1 <<< 15)) >>> 16;
            if (z > HALF_PI) z = HALF_PI;
            // minus pi/2 folds onto plus pi/2
            if (neg && z != HALF_PI) z = -z;
            r.yaw = YAW_W'(z);
        end
        return r;
    endfunction

    // segment with a mix of flat, upright, point-like and free shapes
    function automatic t_line random_line();
        t_line ln;
        int kind;
        kind = $urandom_range(0, 15);
        ln.sx = COORD_W'($urandom);
        ln.sy = COORD_W'($urandom);
        ln.ex = COORD_W'($urandom);
        ln.ey = COORD_W'($urandom);
        ln.last = ($urandom_range(0, 7) == 0);
        case (kind)
            0, 1: ln.ey = ln.sy;                          // flat
            2, 3: ln.ex = ln.sx;                          // upright in the image
            4: begin ln.ex = ln.sx; ln.ey = ln.sy; end    // single point
            5: ln.ey = ln.sy + COORD_W'($urandom_range(0, 6)) - 3;  // nearly flat
            6: begin
                ln.ex = ($urandom_range(0, 1) == 1) ? CMAX : '0;
                ln.sy = ($urandom_range(0, 1) == 1) ? CMAX : '0;
            end
            default: ;
        endcase
        return ln;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        if (idx < REG_SPARE_LO) matrix[idx] = val;
    endtask

    task automatic load_matrix(input logic [CFG_W-1:0] fx, skew, cx, fy, cy);
        write_reg(REG_INV_FX, fx);
        write_reg(REG_INV_SKEW, skew);
        write_reg(REG_INV_CX_TERM, cx);
        write_reg(REG_INV_FY, fy);
        write_reg(REG_INV_CY_TERM, cy);
        // unused indexes must leave the matrix alone
        for (int k = REG_SPARE_LO; k <= REG_SPARE_HI; k++)
            write_reg(CFG_IDX_W'(k), CFG_W'($urandom));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic add_line(input logic [COORD_W-1:0] sx, sy, ex, ey, input logic last);
        t_line ln;
        ln.sx = sx; ln.sy = sy; ln.ex = ex; ln.ey = ey; ln.last = last;
        pending_lines = {pending_lines, ln};
    endtask

    task automatic drain();
        while (pending_lines.size() != 0 || i_valid || expected_angles.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic random_phase(input int n);
        for (int k = 0; k < n; k++) pending_lines = {pending_lines, random_line()};
        drain();
    endtask

    // driver: one transaction offered at a time, held while stalled
    always @(posedge i_clk) begin
        if (i_rst_n && (!i_valid || !o_stall)) begin
            if (i_valid) expected_angles = {expected_angles, line_yaw('{i_start_x, i_start_y,
                                                             i_end_x, i_end_y, i_in_last})};
            if (send_gap > 0) begin
                send_gap--;
                i_valid <= 1'b0;
            end else if (pending_lines.size() != 0) begin
                t_line ln;
                ln = pending_lines.pop_front();
                i_start_x <= ln.sx;
                i_start_y <= ln.sy;
                i_end_x   <= ln.ex;
                i_end_y   <= ln.ey;
                i_in_last <= ln.last;
                i_valid   <= 1'b1;
                if (!calm && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 13);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // monitor: back-pressure bursts and in-order compare
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("line_yaw_angle_core_tb: done, errors");
            $finish;
        end
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (expected_angles.size() == 0) begin
                    report_mismatch("unexpected transaction", o_yaw, 0);
                end else begin
                    t_angle w;
                    w = expected_angles.pop_front();
                    if (o_yaw !== w.yaw) report_mismatch("yaw", o_yaw, w.yaw);
                    if (o_degenerate !== w.degen)
                        report_mismatch("degenerate", o_degenerate, w.degen);
                    if (o_out_last !== w.last) report_mismatch("out_last", o_out_last, w.last);
                end
            end
            if (hold_gap > 0) begin
                hold_gap--;
                i_stall <= 1'b1;
            end else if (!calm && $urandom_range(0, 11) == 0) begin
                hold_gap = $urandom_range(0, 12);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    initial begin
        for (int k = 0; k < 5; k++) matrix[k] = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero matrix: every line is either upright in angle or degenerate
        add_line('0, '0, '0, '0, 1'b0);
        add_line(CMAX, CMAX, CMAX, CMAX, 1'b1);
        add_line('0, '0, CMAX, CMAX, 1'b0);
        add_line(CMAX, CMAX, '0, '0, 1'b1);
        add_line('0, 17'd5, CMAX, 17'd5, 1'b0);
        drain();

        // realistic camera inverse
        load_matrix(32'sd1342177, 32'sd0, -32'sd858993459, 32'sd1342177, -32'sd483183821);
        add_line(17'd100, 17'd100, 17'd900, 17'd100, 1'b0);     // flat
        add_line(17'd100, 17'd100, 17'd100, 17'd900, 1'b0);
        add_line(17'd500, 17'd500, 17'd500, 17'd500, 1'b1);     // single point
        add_line('0, '0, CMAX, CMAX, 1'b0);
        add_line(CMAX, '0, '0, CMAX, 1'b1);
        add_line('0, CMAX, CMAX, '0, 1'b0);
        add_line(17'd10240, 17'd5760, 17'd10240, 17'd9000, 1'b0); // through the centre
        add_line(17'd10240, 17'd5760, 17'd10241, 17'd5761, 1'b1);
        random_phase(RAND_PER_PHASE);

        // only the row-1 terms: dx = 0 gives a vertical tangent
        load_matrix(32'sd0, 32'sd0, 32'sd0, 32'sd70000000, -32'sd300000000);
        add_line(17'd40, 17'd40, 17'd40, 17'd4000, 1'b0);
        add_line(17'd40, 17'd4000, 17'd40, 17'd40, 1'b1);
        random_phase(RAND_PER_PHASE);

        // largest positive entries
        load_matrix(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_line('0, '0, CMAX, CMAX, 1'b0);
        add_line(CMAX, CMAX, '0, '0, 1'b1);
        random_phase(RAND_PER_PHASE);

        // most negative entries
        load_matrix(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        add_line('0, CMAX, CMAX, '0, 1'b0);
        random_phase(RAND_PER_PHASE);

        // random matrix
        load_matrix(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
                    CFG_W'($urandom), CFG_W'($urandom));
        random_phase(RAND_PER_PHASE);

        // closing phase at full rate with no idling
        load_matrix(32'sd1073741, 32'sd2000, -32'sd700000000, 32'sd1073741, -32'sd400000000);
        calm = 1'b1;
        random_phase(RAND_PER_PHASE);

        if (error_count == 0) begin
            $display("line_yaw_angle_core_tb: done, clean");
        end else begin
            $display("line_yaw_angle_core_tb: done, errors");
        end
        $finish;
    end

endmodule
